// ===== hdl/pdm_pkg.sv =====
// Shared types and constants for the PCM mono downmix block.
// No dependencies; imported by every module of the block.
package pdm_pkg;

	localparam int MAX_CHANNELS = 8;
	localparam int CH_W         = 4;
	localparam int SUM_W        = 36;
	localparam int DIV_BITS     = 4;
	localparam int DIV_STEPS    = SUM_W / DIV_BITS;
	localparam int STEP_W       = $clog2(DIV_STEPS);
	localparam int REM_W        = $clog2(MAX_CHANNELS) + 1;
	localparam int REG_IDX_W    = 1;
	localparam int CFG_W        = 4;
	localparam int OUT_W        = 16;

	localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_SAMPLE_FORMAT = 1'b1;

	typedef enum logic [2:0] {
		FMT_S16 = 3'd0,
		FMT_S32 = 3'd1,
		FMT_F32 = 3'd2,
		FMT_U8  = 3'd3,
		FMT_S24 = 3'd4
	} fmt_t;

	// one finished frame handed from the front to the back
	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [CH_W-1:0]         ch;
		logic                    f32;
		logic                    nan;
	} frame_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_SCALE,
		BK_EMIT
	} bk_state_t;

endpackage

// ===== hdl/pdm_front.sv =====
// Front end: configuration registers, per-sample format decode and frame accumulation.
// Depends on pdm_pkg; pushes finished frames into pdm_frame_q.
module pdm_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [31:0]                     sample_word,
	input  logic                            cfg_we,
	input  logic [pdm_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [pdm_pkg::CFG_W-1:0]       cfg_data,
	output logic                            frame_push,
	output pdm_pkg::frame_t                 frame_entry,
	input  logic                            frame_full
);
	import pdm_pkg::*;

	logic [CH_W-1:0]         channel_count_q;
	logic [2:0]              sample_format_q;
	logic signed [SUM_W-1:0] channel_sum_q;
	logic [CH_W-1:0]         channel_index_q;
	logic                    saw_nan_q;

	logic [CH_W-1:0]         ch_eff;
	logic signed [SUM_W-1:0] dec;
	logic                    dec_nan;
	logic                    fmt_ok;
	logic                    take;
	logic                    last;
	logic [CH_W-1:0]         idx_inc;
	logic signed [SUM_W-1:0] sum_next;

	// f32 decode
	logic        f_sign;
	logic [7:0]  f_ex;
	logic [22:0] f_man;
	logic [23:0] f_full;
	logic [7:0]  f_up;
	logic [7:0]  f_dn;
	logic [32:0] f_mag;
	logic [15:0] s16;

	always_comb begin
		if (channel_count_q == '0) begin
			ch_eff = CH_W'(1);
		end else if (channel_count_q > CH_W'(MAX_CHANNELS)) begin
			ch_eff = CH_W'(MAX_CHANNELS);
		end else begin
			ch_eff = channel_count_q;
		end
	end

	always_comb begin
		f_sign  = sample_word[31];
		f_ex    = sample_word[30:23];
		f_man   = sample_word[22:0];
		f_full  = {1'b1, f_man};
		f_up    = f_ex - 8'd126;
		f_dn    = 8'd126 - f_ex;
		dec_nan = 1'b0;
		if (f_ex == 8'hFF && f_man != '0) begin
			dec_nan = 1'b1;
			f_mag   = '0;
		end else if (f_ex == 8'd0) begin
			f_mag = '0;
		end else if (f_ex >= 8'd135) begin
			// saturate to -2^32 or 2^32-1
			f_mag = f_sign ? {1'b1, 32'd0} : {1'b0, 32'hFFFF_FFFF};
		end else if (f_ex >= 8'd126) begin
			f_mag = {9'd0, f_full} << f_up[3:0];
		end else if (f_dn >= 8'd24) begin
			f_mag = '0;
		end else begin
			f_mag = {9'd0, f_full} >> f_dn[4:0];
		end
	end

	always_comb begin
		fmt_ok = 1'b1;
		s16    = '0;
		dec    = '0;
		case (sample_format_q)
			FMT_S16: s16 = sample_word[15:0];
			FMT_S32: s16 = sample_word[31:16];
			FMT_S24: s16 = sample_word[23:8];
			FMT_U8:  s16 = {~sample_word[7], sample_word[6:0], 8'd0};
			FMT_F32: s16 = '0;
			default: fmt_ok = 1'b0;
		endcase
		if (sample_format_q == FMT_F32) begin
			dec = f_sign ? -$signed({3'd0, f_mag}) : $signed({3'd0, f_mag});
		end else begin
			dec = {{(SUM_W-16){s16[15]}}, s16};
		end
	end

	assign full     = frame_full;
	assign take     = push && !frame_full && fmt_ok;
	assign idx_inc  = channel_index_q + CH_W'(1);
	assign last     = idx_inc >= ch_eff;
	assign sum_next = channel_sum_q + dec;

	assign frame_push      = take && last;
	assign frame_entry.sum = sum_next;
	assign frame_entry.ch  = ch_eff;
	assign frame_entry.f32 = (sample_format_q == FMT_F32);
	assign frame_entry.nan = saw_nan_q || (dec_nan && sample_format_q == FMT_F32);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= CH_W'(1);
			sample_format_q <= FMT_S16;
			channel_sum_q   <= '0;
			channel_index_q <= '0;
			saw_nan_q       <= 1'b0;
		end else if (cfg_we) begin
			// any register write drops the partial frame
			if (cfg_index == REG_CHANNEL_COUNT) begin
				channel_count_q <= cfg_data;
			end else begin
				sample_format_q <= cfg_data[2:0];
			end
			channel_sum_q   <= '0;
			channel_index_q <= '0;
			saw_nan_q       <= 1'b0;
		end else if (take) begin
			if (last) begin
				channel_sum_q   <= '0;
				channel_index_q <= '0;
				saw_nan_q       <= 1'b0;
			end else begin
				channel_sum_q   <= sum_next;
				channel_index_q <= idx_inc;
				saw_nan_q       <= frame_entry.nan;
			end
		end
	end

endmodule

// ===== hdl/pdm_frame_q.sv =====
// Two-entry queue of finished frames between the front and the back.
// Depends on pdm_pkg for the frame type.
module pdm_frame_q (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  pdm_pkg::frame_t wr_data,
	output logic            full,
	input  logic            rd,
	output pdm_pkg::frame_t rd_data,
	output logic            empty
);
	import pdm_pkg::*;

	frame_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr && !full) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd && !empty) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(wr && !full) - 2'(rd && !empty);
		end
	end

endmodule

// ===== hdl/pdm_back.sv =====
// Back end: divides a frame sum by its channel count, scales f32 frames, clamps,
// and queues results. Depends on pdm_pkg.
module pdm_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        frame_empty,
	input  pdm_pkg::frame_t             frame_entry,
	output logic                        frame_pop,
	output logic                        empty,
	input  logic                        pop,
	output logic signed [pdm_pkg::OUT_W-1:0] mono_sample
);
	import pdm_pkg::*;

	bk_state_t state_q, state_d;

	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  div_q;
	logic [REM_W-1:0]  rem_q;
	logic [CH_W-1:0]   den_q;
	logic              neg_q;
	logic              f32_q;
	logic              nan_q;

	logic [SUM_W-1:0]  div_nx;
	logic [REM_W-1:0]  rem_nx;
	logic [47:0]       prod;
	logic [SUM_W-1:0]  scaled;
	logic [OUT_W-1:0]  clamped;
	logic              out_push;

	logic [OUT_W-1:0]  out_mem_q [2];
	logic              out_wr_q;
	logic              out_rd_q;
	logic [1:0]        out_cnt_q;
	logic              out_full;

	assign out_full    = (out_cnt_q == 2'd2);
	assign empty       = (out_cnt_q == 2'd0);
	assign mono_sample = out_mem_q[out_rd_q];

	// restoring divide, DIV_BITS quotient bits per cycle; divisor is at most 8
	always_comb begin
		div_nx = div_q;
		rem_nx = rem_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			rem_nx = {rem_nx[REM_W-2:0], div_nx[SUM_W-1]};
			div_nx = {div_nx[SUM_W-2:0], 1'b0};
			if (rem_nx >= REM_W'(den_q)) begin
				rem_nx    = rem_nx - REM_W'(den_q);
				div_nx[0] = 1'b1;
			end
		end
	end

	// f32 mean is within 2^32, so q*32767 fits in 48 bits
	always_comb begin
		prod = {div_q[32:0], 15'd0} - {15'd0, div_q[32:0]};
		if (!f32_q) begin
			scaled = div_q;
		end else if (nan_q) begin
			scaled = '0;
		end else begin
			scaled = {{(SUM_W-24){1'b0}}, prod[47:24]};
		end
	end

	always_comb begin
		if (neg_q) begin
			clamped = (div_q > SUM_W'(32768)) ? 16'h8000 : (16'h0 - div_q[15:0]);
		end else begin
			clamped = (div_q > SUM_W'(32767)) ? 16'h7FFF : div_q[15:0];
		end
	end

	always_comb begin
		state_d   = state_q;
		frame_pop = 1'b0;
		out_push  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!frame_empty) begin
					frame_pop = 1'b1;
					state_d   = BK_DIV;
				end
			end
			BK_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = BK_SCALE;
				end
			end
			BK_SCALE: state_d = BK_EMIT;
			BK_EMIT: begin
				if (!out_full) begin
					out_push = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_DIV && state_d == BK_DIV) begin
				step_q <= step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (frame_pop) begin
					neg_q <= frame_entry.sum[SUM_W-1];
					div_q <= frame_entry.sum[SUM_W-1] ? SUM_W'(-frame_entry.sum)
						: SUM_W'(frame_entry.sum);
					den_q <= frame_entry.ch;
					f32_q <= frame_entry.f32;
					nan_q <= frame_entry.nan;
					rem_q <= '0;
				end
			end
			BK_DIV: begin
				div_q <= div_nx;
				rem_q <= rem_nx;
			end
			BK_SCALE: div_q <= scaled;
			default: ;
		endcase
		if (out_push) begin
			out_mem_q[out_wr_q] <= clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= 1'b0;
			out_rd_q  <= 1'b0;
			out_cnt_q <= 2'd0;
		end else begin
			if (out_push) begin
				out_wr_q <= !out_wr_q;
			end
			if (pop && !empty) begin
				out_rd_q <= !out_rd_q;
			end
			out_cnt_q <= out_cnt_q + 2'(out_push) - 2'(pop && !empty);
		end
	end

`ifndef SYNTHESIS
	a_out_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q <= 2'd2)
		else $error("result queue count overflow");
	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != BK_DIV |-> step_q == '0)
		else $error("divide step counter running outside divide");
	a_nan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SCALE && f32_q && nan_q) |=> div_q == '0)
		else $error("NaN frame did not scale to zero");
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_EMIT && out_full) |=> state_q == BK_EMIT)
		else $error("result dropped while result queue full");
`endif

endmodule

// ===== hdl/pcm_downmix_to_mono16.sv =====
// Top level of the PCM mono downmix block.
// Depends on pdm_pkg, pdm_front, pdm_frame_q and pdm_back.
//
// Feed interleaved channel samples through push/full, one beat per cycle while full
// is low; one signed 16-bit mono sample per frame comes out through empty/pop. The
// front accumulates one sample per accepted beat. Each finished frame then passes
// through the back (load, nine divide steps of four quotient bits, f32 scaling,
// result write, which waits while the result queue is full), and a two-entry frame
// queue sits between them, so the front can gather the next frame while the back
// works on the last. Write configuration only while the block is idle; any register
// write drops a partial frame. Samples of an unknown format are taken and ignored.
module pcm_downmix_to_mono16 (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [31:0]                     sample_word,
	output logic                            empty,
	input  logic                            pop,
	output logic signed [pdm_pkg::OUT_W-1:0] mono_sample,
	input  logic                            cfg_we,
	input  logic [pdm_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [pdm_pkg::CFG_W-1:0]       cfg_data
);
	import pdm_pkg::*;

	logic   fq_wr;
	logic   fq_full;
	logic   fq_rd;
	logic   fq_empty;
	frame_t fq_wr_data;
	frame_t fq_rd_data;

	pdm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.sample_word (sample_word),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.frame_push  (fq_wr),
		.frame_entry (fq_wr_data),
		.frame_full  (fq_full)
	);

	pdm_frame_q u_frame_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (fq_wr),
		.wr_data (fq_wr_data),
		.full    (fq_full),
		.rd      (fq_rd),
		.rd_data (fq_rd_data),
		.empty   (fq_empty)
	);

	pdm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_empty (fq_empty),
		.frame_entry (fq_rd_data),
		.frame_pop   (fq_rd),
		.empty       (empty),
		.pop         (pop),
		.mono_sample (mono_sample)
	);

endmodule

// ===== tb/pcm_downmix_to_mono16_tb.sv =====
// Self-checking testbench for the PCM mono downmix block: a directed table, then random
// phases over channel counts and formats; each result is checked against its table
// value or a local predictor. Depends on pdm_pkg and pcm_downmix_to_mono16.
module pcm_downmix_to_mono16_tb;
	import pdm_pkg::*;

	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_ITEMS = 1450;
	localparam logic [2:0] FMT_BAD = 3'd5;

	typedef enum bit {
		ROW_CFG,
		ROW_SMP
	} row_kind_t;

	typedef struct packed {
		row_kind_t               kind;
		logic [REG_IDX_W-1:0]    idx;
		logic [CFG_W-1:0]        val;
		logic [31:0]             word;
		bit                      typed;
		logic signed [OUT_W-1:0] want;
	} stim_row_t;

	logic                    clk         = 1'b0;
	logic                    arst_n      = 1'b0;
	logic                    push        = 1'b0;
	logic                    full;
	logic [31:0]             sample_word = '0;
	logic                    empty;
	logic                    pop         = 1'b0;
	logic signed [OUT_W-1:0] mono_sample;
	logic                    cfg_we      = 1'b0;
	logic [REG_IDX_W-1:0]    cfg_index   = '0;
	logic [CFG_W-1:0]        cfg_data    = '0;

	// predictor copy of the block's registers and frame state
	logic [CH_W-1:0] pred_ch  = 4'd1;
	logic [2:0]      pred_fmt = FMT_S16;
	longint          acc_sum  = 0;
	int              acc_idx  = 0;
	bit              acc_nan  = 1'b0;

	logic signed [OUT_W-1:0] mono_exp_q[$];
	int                      mismatch_cnt = 0;

	int unsigned rx_cyc  = 0;
	logic [1:0]  rx_mode = 2'd0;
	logic [15:0] rx_pat  = 16'hFFFF;

	always #5 clk = ~clk;

	pcm_downmix_to_mono16 i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.sample_word (sample_word),
		.empty       (empty),
		.pop         (pop),
		.mono_sample (mono_sample),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	task automatic report_mismatch(input string what, input logic signed [OUT_W-1:0] want,
		input logic signed [OUT_W-1:0] got);
		$display("mismatch: %s: expected %0d, got %0d", what, want, got);
		mismatch_cnt++;
	endtask

	// float bits to signed Q8.24, magnitude truncated, saturating at +-2^32
	function automatic longint f32_to_fix(input logic [31:0] w, output bit is_nan);
		logic [7:0]      ex;
		logic [23:0]     mant;
		longint unsigned mag;
		int              sh;
		ex     = w[30:23];
		mant   = {1'b1, w[22:0]};
		is_nan = 1'b0;
		if (ex == 8'hFF && w[22:0] != 0) begin
			is_nan = 1'b1;
			return 0;
		end
		if (ex == 8'd0) begin
			mag = 0;
		end else if (ex >= 8'd135) begin
			return w[31] ? -64'sd4294967296 : 64'sd4294967295;
		end else if (ex >= 8'd126) begin
			mag = longint'(mant) << (ex - 8'd126);
		end else begin
			sh  = 126 - int'(ex);
			mag = (sh >= 24) ? 0 : (longint'(mant) >> sh);
		end
		return w[31] ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic void clear_frame();
		acc_sum = 0;
		acc_idx = 0;
		acc_nan = 1'b0;
	endfunction

	function automatic void apply_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		if (idx == REG_CHANNEL_COUNT)
			pred_ch = val;
		else
			pred_fmt = val[2:0];
		clear_frame();
	endfunction

	// one channel sample in; returns 1 with the mono sample when a frame completes
	function automatic bit downmix_step(input logic [31:0] w, output logic signed [OUT_W-1:0] mono);
		longint dec;
		longint mean;
		int     ch;
		bit     nan;
		mono = '0;
		nan  = 1'b0;
		ch   = (pred_ch == 0) ? 1 : ((pred_ch > MAX_CHANNELS) ? MAX_CHANNELS : int'(pred_ch));
		case (pred_fmt)
			FMT_S16: dec = longint'($signed(w[15:0]));
			FMT_S32: dec = longint'($signed(w[31:16]));
			FMT_U8:  dec = (longint'(w[7:0]) - 128) * 256;
			FMT_S24: dec = longint'($signed(w[23:8]));
			FMT_F32: dec = f32_to_fix(w, nan);
			default: return 1'b0;
		endcase
		if (nan)
			acc_nan = 1'b1;
		acc_sum += dec;
		acc_idx++;
		if (acc_idx < ch)
			return 1'b0;
		mean = acc_sum / ch;
		if (pred_fmt == FMT_F32)
			mean = acc_nan ? 0 : (mean * 32767) / 16777216;
		if (mean < -32768)
			mean = -32768;
		if (mean > 32767)
			mean = 32767;
		mono = mean[OUT_W-1:0];
		clear_frame();
		return 1'b1;
	endfunction

	function automatic logic [31:0] gen_word();
		logic [31:0] w;
		w = $urandom;
		if (pred_fmt == FMT_F32) begin
			case ($urandom_range(0, 39))
				0: w = {w[31], 31'd0};
				1: w = {w[31], 8'hFF, 23'd0};
				2: w = {w[31], 8'hFF, w[22:1], 1'b1};
				3: w = {w[31], 8'h00, w[22:0]};
				4, 5: ;
				default: w = {w[31], 8'($urandom_range(100, 140)), w[22:0]};
			endcase
		end else begin
			case ($urandom_range(0, 9))
				0: w = 32'hFFFF_FFFF;
				1: w = 32'h0000_0000;
				2: begin
					case ($urandom_range(0, 7))
						0: w = 32'h8000_0000;
						1: w = 32'h7FFF_FFFF;
						2: w = 32'h0000_8000;
						3: w = 32'h0000_7FFF;
						4: w = 32'h0080_0000;
						5: w = 32'h007F_FFFF;
						6: w = 32'h0000_0080;
						default: w = 32'h0000_007F;
					endcase
				end
				default: ;
			endcase
		end
		return w;
	endfunction

	function automatic stim_row_t cfg_row(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		return '{kind: ROW_CFG, idx: idx, val: val, word: '0, typed: 1'b0, want: '0};
	endfunction

	function automatic stim_row_t smp_row(input logic [31:0] w, input bit typed,
		input logic signed [OUT_W-1:0] want);
		return '{kind: ROW_SMP, idx: '0, val: '0, word: w, typed: typed, want: want};
	endfunction

	// beat stays offered until accepted; push is left high for the caller
	task automatic send_word(input logic [31:0] w, input bit typed, input logic signed [OUT_W-1:0] want);
		logic signed [OUT_W-1:0] mono;
		push        <= 1'b1;
		sample_word <= w;
		do
			@(posedge clk);
		while (full);
		if (downmix_step(w, mono))
			mono_exp_q.push_back(typed ? want : mono);
	endtask

	task automatic send_burst(input int n);
		for (int i = 0; i < n; i++)
			send_word(gen_word(), 1'b0, '0);
		push <= 1'b0;
	endtask

	// only with the block drained: results all in, and time for ignored beats to settle
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		while (mono_exp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_reg(idx, val);
	endtask

	// result side: pop driven by a randomly chosen stall pattern
	always @(posedge clk) begin
		rx_cyc <= rx_cyc + 1;
		if (rx_cyc[5:0] == 6'd0) begin
			rx_mode <= 2'($urandom_range(0, 3));
			rx_pat  <= 16'($urandom);
		end
		case (rx_mode)
			2'd0: pop <= 1'b1;
			2'd1: pop <= 1'($urandom_range(0, 1));
			2'd2: pop <= ($urandom_range(0, 7) == 0);
			default: pop <= rx_pat[rx_cyc[3:0]];
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (mono_exp_q.size() == 0)
				report_mismatch("unexpected result", '0, mono_sample);
			else if (mono_sample !== mono_exp_q[0])
				report_mismatch("mono_sample", mono_exp_q.pop_front(), mono_sample);
			else
				void'(mono_exp_q.pop_front());
		end
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		stim_row_t   dir_tab[$];
		int          counted;
		int          phase;
		int          n;
		int          left;
		int          blen;
		int          gap;
		logic [3:0]  ch_val;
		logic [2:0]  fmt_val;
		logic [3:0]  fmt_data;

		dir_tab = '{
			// reset settings: one channel, s16
			smp_row(32'h0000_7FFF, 1'b1, 16'sd32767),
			smp_row(32'hFFFF_8000, 1'b1, -16'sd32768),
			smp_row(32'h1234_0000, 1'b1, 16'sd0),
			cfg_row(REG_SAMPLE_FORMAT, {1'b0, FMT_S32}),
			smp_row(32'h8000_0000, 1'b1, -16'sd32768),
			smp_row(32'h7FFF_FFFF, 1'b1, 16'sd32767),
			cfg_row(REG_SAMPLE_FORMAT, {1'b0, FMT_U8}),
			smp_row(32'h0000_0000, 1'b1, -16'sd32768),
			smp_row(32'hFFFF_FFFF, 1'b1, 16'sd32512),
			cfg_row(REG_SAMPLE_FORMAT, {1'b0, FMT_S24}),
			smp_row(32'h0080_0000, 1'b1, -16'sd32768),
			smp_row(32'h007F_FFFF, 1'b1, 16'sd32767),
			// top data bit is outside the format field
			cfg_row(REG_SAMPLE_FORMAT, {1'b1, FMT_F32}),
			smp_row(32'h3F80_0000, 1'b1, 16'sd32767),
			smp_row(32'hBF80_0000, 1'b1, -16'sd32767),
			smp_row(32'h7F80_0000, 1'b1, 16'sd32767),
			smp_row(32'hFF80_0000, 1'b1, -16'sd32768),
			smp_row(32'h7FC0_0000, 1'b1, 16'sd0),
			smp_row(32'h0000_0001, 1'b1, 16'sd0),
			// zero channels counts as one
			cfg_row(REG_CHANNEL_COUNT, 4'd0),
			smp_row(32'h3F00_0000, 1'b1, 16'sd16383),
			// unknown format: beat taken, nothing comes out
			cfg_row(REG_SAMPLE_FORMAT, {1'b0, FMT_BAD}),
			smp_row(32'h0000_1234, 1'b0, '0),
			cfg_row(REG_SAMPLE_FORMAT, {1'b0, FMT_S16}),
			cfg_row(REG_CHANNEL_COUNT, 4'd2),
			smp_row(32'h0000_7FFF, 1'b0, '0),
			smp_row(32'h0000_7FFF, 1'b1, 16'sd32767),
			smp_row(32'h0000_8000, 1'b0, '0),
			smp_row(32'h0000_7FFF, 1'b1, 16'sd0),
			// half frame, then dropped by a register write
			smp_row(32'h0000_1234, 1'b0, '0),
			cfg_row(REG_CHANNEL_COUNT, 4'd3),
			cfg_row(REG_SAMPLE_FORMAT, {1'b0, FMT_F32}),
			smp_row(32'h3F80_0000, 1'b0, '0),
			smp_row(32'h7FC0_0001, 1'b0, '0),
			smp_row(32'h3F80_0000, 1'b1, 16'sd0)
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG) begin
				write_reg(dir_tab[i].idx, dir_tab[i].val);
			end else begin
				send_word(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].want);
				push <= 1'b0;
				@(posedge clk);
			end
		end

		counted = 0;
		phase   = 0;
		while (counted < RANDOM_ITEMS) begin
			case (phase)
				0: begin
					ch_val  = 4'd1;
					fmt_val = FMT_S16;
				end
				1: begin
					ch_val  = 4'd8;
					fmt_val = FMT_F32;
				end
				2: begin
					ch_val  = 4'd15;
					fmt_val = FMT_S24;
				end
				3: begin
					ch_val  = 4'd0;
					fmt_val = FMT_U8;
				end
				4: begin
					ch_val  = 4'd8;
					fmt_val = FMT_S32;
				end
				default: begin
					ch_val  = 4'($urandom_range(0, 15));
					fmt_val = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
						: 3'($urandom_range(0, 4));
				end
			endcase
			fmt_data = {1'($urandom_range(0, 1)), fmt_val};
			if ($urandom_range(0, 1)) begin
				write_reg(REG_CHANNEL_COUNT, ch_val);
				write_reg(REG_SAMPLE_FORMAT, fmt_data);
			end else begin
				write_reg(REG_SAMPLE_FORMAT, fmt_data);
				write_reg(REG_CHANNEL_COUNT, ch_val);
			end

			n    = (fmt_val > FMT_S24) ? $urandom_range(3, 8) : $urandom_range(60, 160);
			left = n;
			while (left > 0) begin
				blen = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
				if (blen > left)
					blen = left;
				send_burst(blen);
				left -= blen;
				gap = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 4);
				repeat (gap) @(posedge clk);
				// hold the sender off until the result side has caught up
				if (phase == 2 || $urandom_range(0, 19) == 0)
					while (mono_exp_q.size() != 0)
						@(posedge clk);
			end
			if (fmt_val <= FMT_S24)
				counted += n;
			phase++;
		end

		while (mono_exp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && mono_exp_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
